>>> rtl/core/slt_pkg.sv
// Shared widths, codes and controller/datapath interface types for the sparse link table.
package slt_pkg;

    // Field widths of the stream beats and the register port
    localparam int CMD_W       = 2;
    localparam int ROW_SEL_W   = 6;
    localparam int COL_SEL_W   = 7;
    localparam int STATUS_W    = 2;
    localparam int ROW_LINKS_W = 8;
    localparam int COL_LINKS_W = 7;
    localparam int TOTAL_W     = 14;
    localparam int RIN_W       = 7;
    localparam int CIN_W       = 8;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 48;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    // Register reset values
    localparam logic [RIN_W-1:0] ROWS_IN_USE_RST = 7'd64;
    localparam logic [CIN_W-1:0] COLS_IN_USE_RST = 8'd128;

    // Register index, taken from the word address bit
    localparam logic REG_ROWS_IN_USE = 1'b0;
    localparam logic REG_COLS_IN_USE = 1'b1;

    // Command codes; a query and the unused code change nothing
    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EXISTS  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic clr_wr;
        logic capture;
        logic eval;
        logic hist_a;
        logic hist_b;
        logic load_out;
    } t_slt_ctl;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clr_last;
        logic act;
    } t_slt_sts;

endpackage

>>> rtl/core/slt_dp.sv
// Datapath of the sparse link table: link bitmap, degree stores, degree histograms and results.
module slt_dp #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 128
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  slt_pkg::t_slt_ctl                 i_ctl,
    output slt_pkg::t_slt_sts                 o_sts,
    input  logic [slt_pkg::CMD_W-1:0]         i_cmd,
    input  logic [slt_pkg::ROW_SEL_W-1:0]     i_row_sel,
    input  logic [slt_pkg::COL_SEL_W-1:0]     i_col_sel,
    input  logic [slt_pkg::RIN_W-1:0]         i_rows_in_use,
    input  logic [slt_pkg::CIN_W-1:0]         i_cols_in_use,
    output logic [slt_pkg::STATUS_W-1:0]      o_status,
    output logic                              o_present,
    output logic [slt_pkg::ROW_LINKS_W-1:0]   o_row_links,
    output logic [slt_pkg::COL_LINKS_W-1:0]   o_col_links,
    output logic [slt_pkg::ROW_LINKS_W-1:0]   o_max_row_links,
    output logic [slt_pkg::COL_LINKS_W-1:0]   o_max_col_links,
    output logic [slt_pkg::TOTAL_W-1:0]       o_total_links
);
    import slt_pkg::*;

    localparam int RW      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RDW     = $clog2(MAX_COLS + 1);
    localparam int CDW     = $clog2(MAX_ROWS + 1);
    localparam int TW      = $clog2(MAX_ROWS * MAX_COLS + 1);
    localparam int CLR_LEN = ((MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS) + 1;
    localparam int KW      = $clog2(CLR_LEN);

    // Stores. The row histogram counts rows per row degree, the column
    // histogram columns per column degree; entry zero is never used.
    logic [MAX_COLS-1:0] m_bitmap [MAX_ROWS];
    logic [RDW-1:0]      m_rdeg   [MAX_ROWS];
    logic [CDW-1:0]      m_cdeg   [MAX_COLS];
    logic [CDW-1:0]      m_rhist  [MAX_COLS + 1];
    logic [RDW-1:0]      m_chist  [MAX_ROWS + 1];

    logic [KW-1:0]       r_clr_cnt;
    logic [CMD_W-1:0]    r_cmd;
    logic [RW-1:0]       r_row;
    logic [CW-1:0]       r_col;
    logic                r_in_range;
    logic [MAX_COLS-1:0] r_bm_q;
    logic [RDW-1:0]      r_rdeg_q;
    logic [CDW-1:0]      r_cdeg_q;
    logic [CDW-1:0]      r_rh_q;
    logic [RDW-1:0]      r_ch_q;
    logic [RDW-1:0]      r_rh_a;
    logic [RDW-1:0]      r_rh_b;
    logic [CDW-1:0]      r_ch_a;
    logic [CDW-1:0]      r_ch_b;
    logic                r_do_add;
    logic [RDW-1:0]      r_rdeg_old;
    logic [CDW-1:0]      r_cdeg_old;
    logic [RDW-1:0]      r_rmax;
    logic [CDW-1:0]      r_cmax;
    logic [TW-1:0]       r_total;
    logic [STATUS_W-1:0] r_status;
    logic                r_present;
    logic [RDW-1:0]      r_row_links;
    logic [CDW-1:0]      r_col_links;

    logic                row_ok;
    logic                col_ok;
    logic                here;
    logic                is_add;
    logic                is_rem;
    logic                do_add;
    logic                do_rem;
    logic [MAX_COLS-1:0] col_mask;
    logic [RDW-1:0]      rdeg_inc;
    logic [RDW-1:0]      rdeg_dec;
    logic [RDW-1:0]      rdeg_new;
    logic [CDW-1:0]      cdeg_inc;
    logic [CDW-1:0]      cdeg_dec;
    logic [CDW-1:0]      cdeg_new;
    logic [RDW-1:0]      rh_raddr;
    logic [CDW-1:0]      ch_raddr;

    // Index check against the registers, limited to the table size
    assign row_ok = (32'(i_row_sel) < 32'(i_rows_in_use)) && (32'(i_row_sel) < 32'(MAX_ROWS));
    assign col_ok = (32'(i_col_sel) < 32'(i_cols_in_use)) && (32'(i_col_sel) < 32'(MAX_COLS));

    // Decision on the words read for the current beat
    always_comb begin
        here     = r_bm_q[r_col];
        is_add   = (r_cmd == CMD_ADD);
        is_rem   = (r_cmd == CMD_REMOVE);
        do_add   = r_in_range && is_add && !here;
        do_rem   = r_in_range && is_rem && here;
        col_mask = MAX_COLS'(1) << r_col;
        rdeg_inc = r_rdeg_q + RDW'(1);
        rdeg_dec = r_rdeg_q - RDW'(1);
        cdeg_inc = r_cdeg_q + CDW'(1);
        cdeg_dec = r_cdeg_q - CDW'(1);
        rdeg_new = do_add ? rdeg_inc : (do_rem ? rdeg_dec : r_rdeg_q);
        cdeg_new = do_add ? cdeg_inc : (do_rem ? cdeg_dec : r_cdeg_q);
        // First histogram entry: the new degree on an add, the old one on a remove
        rh_raddr = i_ctl.hist_a ? r_rh_b : (do_add ? rdeg_inc : r_rdeg_q);
        ch_raddr = i_ctl.hist_a ? r_ch_b : (do_add ? cdeg_inc : r_cdeg_q);
    end

    assign o_sts.act      = do_add || do_rem;
    assign o_sts.clr_last = (r_clr_cnt == KW'(CLR_LEN - 1));

    // Clearing pass counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_ctl.clr_wr) begin
            r_clr_cnt <= r_clr_cnt + KW'(1);
        end
    end

    // Link bitmap: cleared row by row, one row written back per update
    always_ff @(posedge i_clk) begin
        if (i_ctl.clr_wr) begin
            if (32'(r_clr_cnt) < 32'(MAX_ROWS)) begin
                m_bitmap[r_clr_cnt[RW-1:0]] <= '0;
            end
        end else if (i_ctl.eval && (do_add || do_rem)) begin
            m_bitmap[r_row] <= do_add ? (r_bm_q | col_mask) : (r_bm_q & ~col_mask);
        end
        r_bm_q <= m_bitmap[r_row];
    end

    // Row degrees
    always_ff @(posedge i_clk) begin
        if (i_ctl.clr_wr) begin
            if (32'(r_clr_cnt) < 32'(MAX_ROWS)) begin
                m_rdeg[r_clr_cnt[RW-1:0]] <= '0;
            end
        end else if (i_ctl.eval && (do_add || do_rem)) begin
            m_rdeg[r_row] <= rdeg_new;
        end
        r_rdeg_q <= m_rdeg[r_row];
    end

    // Column degrees
    always_ff @(posedge i_clk) begin
        if (i_ctl.clr_wr) begin
            if (32'(r_clr_cnt) < 32'(MAX_COLS)) begin
                m_cdeg[r_clr_cnt[CW-1:0]] <= '0;
            end
        end else if (i_ctl.eval && (do_add || do_rem)) begin
            m_cdeg[r_col] <= cdeg_new;
        end
        r_cdeg_q <= m_cdeg[r_col];
    end

    // Row degree histogram: the first entry moves in the first step,
    // the second entry (degree zero is not kept) in the second
    always_ff @(posedge i_clk) begin
        if (i_ctl.clr_wr) begin
            if (32'(r_clr_cnt) <= 32'(MAX_COLS)) begin
                m_rhist[r_clr_cnt[RDW-1:0]] <= '0;
            end
        end else if (i_ctl.hist_a) begin
            m_rhist[r_rh_a] <= r_do_add ? (r_rh_q + CDW'(1)) : (r_rh_q - CDW'(1));
        end else if (i_ctl.hist_b && (r_rh_b != '0)) begin
            m_rhist[r_rh_b] <= r_do_add ? (r_rh_q - CDW'(1)) : (r_rh_q + CDW'(1));
        end
        r_rh_q <= m_rhist[rh_raddr];
    end

    // Column degree histogram, same scheme
    always_ff @(posedge i_clk) begin
        if (i_ctl.clr_wr) begin
            if (32'(r_clr_cnt) <= 32'(MAX_ROWS)) begin
                m_chist[r_clr_cnt[CDW-1:0]] <= '0;
            end
        end else if (i_ctl.hist_a) begin
            m_chist[r_ch_a] <= r_do_add ? (r_ch_q + RDW'(1)) : (r_ch_q - RDW'(1));
        end else if (i_ctl.hist_b && (r_ch_b != '0)) begin
            m_chist[r_ch_b] <= r_do_add ? (r_ch_q - RDW'(1)) : (r_ch_q + RDW'(1));
        end
        r_ch_q <= m_chist[ch_raddr];
    end

    // Beat capture and per-beat working registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_cmd      <= i_cmd;
            r_row      <= RW'(i_row_sel);
            r_col      <= CW'(i_col_sel);
            r_in_range <= row_ok && col_ok;
        end
        if (i_ctl.eval) begin
            r_do_add   <= do_add;
            r_rdeg_old <= r_rdeg_q;
            r_cdeg_old <= r_cdeg_q;
            r_rh_a     <= do_add ? rdeg_inc : r_rdeg_q;
            r_rh_b     <= do_add ? r_rdeg_q : rdeg_dec;
            r_ch_a     <= do_add ? cdeg_inc : r_cdeg_q;
            r_ch_b     <= do_add ? r_cdeg_q : cdeg_dec;
            r_present  <= r_in_range && (do_add || (here && !do_rem));
            r_row_links <= r_in_range ? rdeg_new : '0;
            r_col_links <= r_in_range ? cdeg_new : '0;
            if (!r_in_range) begin
                r_status <= STATUS_RANGE;
            end else if (is_add && here) begin
                r_status <= STATUS_EXISTS;
            end else if (is_rem && !here) begin
                r_status <= STATUS_MISSING;
            end else begin
                r_status <= STATUS_OK;
            end
        end
    end

    // Maxima and total. An add can only raise a maximum; a remove lowers it by
    // one when the last row or column at the maximum degree leaves it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rmax  <= '0;
            r_cmax  <= '0;
            r_total <= '0;
        end else if (i_ctl.eval) begin
            if (do_add) begin
                r_total <= r_total + TW'(1);
                if (rdeg_inc > r_rmax) begin
                    r_rmax <= rdeg_inc;
                end
                if (cdeg_inc > r_cmax) begin
                    r_cmax <= cdeg_inc;
                end
            end else if (do_rem) begin
                r_total <= r_total - TW'(1);
            end
        end else if (i_ctl.hist_a && !r_do_add) begin
            if ((r_rh_q == CDW'(1)) && (r_rdeg_old == r_rmax)) begin
                r_rmax <= r_rdeg_old - RDW'(1);
            end
            if ((r_ch_q == RDW'(1)) && (r_cdeg_old == r_cmax)) begin
                r_cmax <= r_cdeg_old - CDW'(1);
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_out) begin
            o_status        <= r_status;
            o_present       <= r_present;
            o_row_links     <= ROW_LINKS_W'(r_row_links);
            o_col_links     <= COL_LINKS_W'(r_col_links);
            o_max_row_links <= ROW_LINKS_W'(r_rmax);
            o_max_col_links <= COL_LINKS_W'(r_cmax);
            o_total_links   <= TOTAL_W'(r_total);
        end
    end

`ifndef ASSERT_OFF
    // An empty table has no row or column of nonzero degree
    a_empty_no_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.load_out && (r_total == '0)) |-> ((r_rmax == '0) && (r_cmax == '0)))
        else $error("maximum degree nonzero with no links stored");
`endif

endmodule

>>> rtl/core/slt_ctrl.sv
// Controller of the sparse link table: clearing pass, command sequencing and result handshake.
module slt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    input  slt_pkg::t_slt_sts i_sts,
    output slt_pkg::t_slt_ctl o_ctl
);
    import slt_pkg::*;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_RD,
        S_EV,
        S_HA,
        S_HB,
        S_OUT
    } t_state;

    t_state r_state;
    logic   r_m_valid;
    logic   accept;
    logic   out_free;

    // Commands follow the state; a beat is taken only while idle
    always_comb begin
        o_s_tready     = (r_state == S_IDLE);
        accept         = i_s_tvalid && o_s_tready;
        out_free       = !r_m_valid || i_m_tready;
        o_ctl.clr_wr   = (r_state == S_CLR);
        o_ctl.capture  = accept;
        o_ctl.eval     = (r_state == S_EV);
        o_ctl.hist_a   = (r_state == S_HA);
        o_ctl.hist_b   = (r_state == S_HB);
        o_ctl.load_out = (r_state == S_OUT) && out_free;
    end

    assign o_m_tvalid = r_m_valid;

    // State and result-valid register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_m_valid <= 1'b0;
        end else begin
            case (r_state)
                S_CLR: begin
                    if (i_sts.clr_last) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_EV;
                end
                S_EV: begin
                    r_state <= i_sts.act ? S_HA : S_OUT;
                end
                S_HA: begin
                    r_state <= S_HB;
                end
                S_HB: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (o_ctl.load_out) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

`ifndef ASSERT_OFF
    // A command that changes nothing goes straight to the result
    a_no_act_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EV) && !i_sts.act) |=> (r_state == S_OUT))
        else $error("non-updating command entered the histogram steps");

    // The datapath is given at most one step per cycle
    a_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_ctl.clr_wr, o_ctl.capture, o_ctl.eval,
                  o_ctl.hist_a, o_ctl.hist_b, o_ctl.load_out}))
        else $error("more than one datapath step in a cycle");

    // A result appears only from the result state
    a_valid_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_m_valid) |-> $past(r_state == S_OUT))
        else $error("result valid raised outside the result state");
`endif

endmodule

>>> rtl/core/sparse_link_table_with_degrees.sv
// Top level of the sparse link table: register port, stream ports, controller and datapath.
// The block stores a binary sparse matrix as a bitmap of row-column links and answers one
// query, add or remove per input beat with one result beat carrying the status, the link
// bit, the degrees of the addressed row and column, both maximum degrees and the link
// count. After acceptance each beat passes through the read state S_RD and the evaluate
// state S_EV; a query, a rejected command or a command that changes nothing then goes to
// the result state S_OUT, while an add or remove that changes the table first spends the
// histogram steps S_HA and S_HB on read-modify-write of the degree histograms, each of
// which has a single write port. S_RD reads the bitmap row and both degree stores. The
// next beat is taken while a result still waits in the output register. After reset a
// clearing pass zeroes the stores and no beat is accepted; register writes are taken
// at any time but should be made only while the block is idle.
module sparse_link_table_with_degrees #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 128
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Register port
    input  logic                              i_psel,
    input  logic                              i_penable,
    input  logic                              i_pwrite,
    input  logic [slt_pkg::APB_AW-1:0]        i_paddr,
    input  logic [slt_pkg::APB_DW-1:0]        i_pwdata,
    output logic [slt_pkg::APB_DW-1:0]        o_prdata,
    output logic                              o_pready,
    // Command stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // cmd[1:0], row_sel[7:2], col_sel[14:8], zero [15]
    input  logic [slt_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    // Result stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // status[1:0], present[2], row_links[10:3], col_links[17:11],
    // max_row_links[25:18], max_col_links[32:26], total_links[46:33], zero [47]
    output logic [slt_pkg::OUT_TDATA_W-1:0]   o_m_tdata
);
    import slt_pkg::*;

    logic [RIN_W-1:0]       r_rows_in_use;
    logic [CIN_W-1:0]       r_cols_in_use;
    logic                   cfg_wr;
    logic                   cfg_idx;
    t_slt_ctl               ctl;
    t_slt_sts               sts;
    logic [STATUS_W-1:0]    res_status;
    logic                   res_present;
    logic [ROW_LINKS_W-1:0] res_row_links;
    logic [COL_LINKS_W-1:0] res_col_links;
    logic [ROW_LINKS_W-1:0] res_max_row_links;
    logic [COL_LINKS_W-1:0] res_max_col_links;
    logic [TOTAL_W-1:0]     res_total_links;

    // Register port: one word per register, byte bits ignored
    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel && i_penable && i_pwrite;
    assign cfg_idx  = i_paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_in_use <= ROWS_IN_USE_RST;
            r_cols_in_use <= COLS_IN_USE_RST;
        end else if (cfg_wr) begin
            if (cfg_idx == REG_ROWS_IN_USE) begin
                r_rows_in_use <= i_pwdata[RIN_W-1:0];
            end else begin
                r_cols_in_use <= i_pwdata[CIN_W-1:0];
            end
        end
    end

    always_comb begin
        if (cfg_idx == REG_COLS_IN_USE) begin
            o_prdata = APB_DW'(r_cols_in_use);
        end else begin
            o_prdata = APB_DW'(r_rows_in_use);
        end
    end

    // Sequencing
    slt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    // Table and counters
    slt_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .o_sts           (sts),
        .i_cmd           (i_s_tdata[1:0]),
        .i_row_sel       (i_s_tdata[7:2]),
        .i_col_sel       (i_s_tdata[14:8]),
        .i_rows_in_use   (r_rows_in_use),
        .i_cols_in_use   (r_cols_in_use),
        .o_status        (res_status),
        .o_present       (res_present),
        .o_row_links     (res_row_links),
        .o_col_links     (res_col_links),
        .o_max_row_links (res_max_row_links),
        .o_max_col_links (res_max_col_links),
        .o_total_links   (res_total_links)
    );

    // Result beat packing
    assign o_m_tdata = {1'b0, res_total_links, res_max_col_links, res_max_row_links,
                        res_col_links, res_row_links, res_present, res_status};

endmodule
